>>> hw/rtl/pcd_pkg.sv
// Shared constants and controller/datapath handshake types for the prime counter.
`timescale 1ns / 1ps

package pcd_pkg;

  // Default field widths
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned COUNT_BITS = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new item and seed the divisor
    logic div_start;  // clear the remainder and point at the top dividend bit
    logic div_step;   // one restoring remainder step
    logic next_d;     // advance the divisor and its square
    logic publish;    // load the result register and update the count
    logic prime;      // verdict that goes with publish
  } pcd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic le_one;     // value is 1 or less
    logic sq_over;    // divisor squared exceeds the value
    logic div_last;   // remainder step on the lowest dividend bit
    logic rem_zero;   // divisor divides the value
  } pcd_status_t;

endpackage

>>> hw/rtl/pcd_if.sv
// Item and result channel interfaces for the prime counter.
`timescale 1ns / 1ps

interface pcd_item_if #(
  parameter int unsigned VALUE_BITS = pcd_pkg::VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface pcd_result_if #(
  parameter int unsigned COUNT_BITS = pcd_pkg::COUNT_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  is_prime;
  logic [COUNT_BITS-1:0] prime_count;
  logic                  run_end;

  modport source (output valid, output is_prime, output prime_count, output run_end,
                  input ready);
  modport sink   (input valid, input is_prime, input prime_count, input run_end,
                  output ready);
endinterface

>>> hw/rtl/pcd_ctrl.sv
// Controller state machine: sequences trial division and result hand-off.
`timescale 1ns / 1ps

module pcd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pcd_pkg::pcd_status_t sts_i,
  output pcd_pkg::pcd_cmd_t    cmd_o
);
  import pcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   verdict_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode commands from the current state
  always_comb begin
    cmd_o = '0;
    cmd_o.prime = verdict_q;
    unique case (state_q)
      ST_IDLE:   cmd_o.load = in_valid_i;
      ST_CHECK:  cmd_o.div_start = !sts_i.le_one && !sts_i.sq_over;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_EVAL:   cmd_o.next_d = !sts_i.rem_zero;
      ST_FINISH: cmd_o.publish = !out_valid_q || out_ready_i;
      default:   cmd_o = '0;
    endcase
  end

  // Hold state, verdict and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          priority if (sts_i.le_one) begin
            verdict_q <= 1'b0;
            state_q   <= ST_FINISH;
          end else if (sts_i.sq_over) begin
            verdict_q <= 1'b1;
            state_q   <= ST_FINISH;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (sts_i.div_last) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (sts_i.rem_zero) begin
            verdict_q <= 1'b0;
            state_q   <= ST_FINISH;
          end else begin
            state_q <= ST_CHECK;
          end
        end
        ST_FINISH: begin
          if (cmd_o.publish) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/pcd_datapath.sv
// Datapath: divisor, square tracker, bit-serial remainder unit, run counter, result register.
`timescale 1ns / 1ps

module pcd_datapath #(
  parameter int unsigned VALUE_BITS = pcd_pkg::VALUE_BITS,
  parameter int unsigned COUNT_BITS = pcd_pkg::COUNT_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pcd_pkg::pcd_cmd_t            cmd_i,
  output pcd_pkg::pcd_status_t         sts_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         last_i,
  output logic                         is_prime_o,
  output logic [COUNT_BITS-1:0]        prime_count_o,
  output logic                         run_end_o
);
  import pcd_pkg::*;

  localparam int unsigned BitW = $clog2(VALUE_BITS);
  localparam logic [BitW-1:0]         TopBit  = BitW'(VALUE_BITS - 1);
  localparam logic [VALUE_BITS-2:0]   TwoLow  = (VALUE_BITS - 1)'(2);
  localparam logic [VALUE_BITS-1:0]   FirstD  = VALUE_BITS'(2);
  localparam logic [VALUE_BITS:0]     FirstSq = (VALUE_BITS + 1)'(4);

  logic [VALUE_BITS-1:0] n_q;
  logic                  last_q;
  logic                  small_q;
  logic [VALUE_BITS-1:0] d_q;
  logic [VALUE_BITS:0]   sq_q;
  logic [VALUE_BITS-1:0] rem_q;
  logic [BitW-1:0]       bit_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  is_prime_q;
  logic [COUNT_BITS-1:0] prime_count_q;
  logic                  run_end_q;

  logic                  small_in;
  logic [VALUE_BITS:0]   rem_shift;
  logic [VALUE_BITS:0]   rem_trial;
  logic [VALUE_BITS-1:0] rem_d;
  logic [COUNT_BITS-1:0] count_inc;

  // Values of 1 or less: negative, or a low part below two
  assign small_in = value_i[VALUE_BITS-1] || (value_i[VALUE_BITS-2:0] < TwoLow);

  // One restoring remainder step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_shift = {rem_q, n_q[bit_q]};
    rem_trial = rem_shift - {1'b0, d_q};
    if (rem_shift >= {1'b0, d_q}) begin
      rem_d = rem_trial[VALUE_BITS-1:0];
    end else begin
      rem_d = rem_shift[VALUE_BITS-1:0];
    end
  end

  // Saturating increment on a prime
  assign count_inc = count_q + COUNT_BITS'(cmd_i.prime && (count_q != '1));

  assign sts_o.le_one   = small_q;
  assign sts_o.sq_over  = (sq_q > {1'b0, n_q});
  assign sts_o.div_last = (bit_q == '0);
  assign sts_o.rem_zero = (rem_q == '0);

  assign is_prime_o    = is_prime_q;
  assign prime_count_o = prime_count_q;
  assign run_end_o     = run_end_q;

  // Run counter: bump on a published prime, clear after the last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.publish) begin
      count_q <= last_q ? '0 : count_inc;
    end
  end

  // Working registers and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= value_i;
      last_q  <= last_i;
      small_q <= small_in;
      d_q     <= FirstD;
      sq_q    <= FirstSq;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      bit_q <= TopBit;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      bit_q <= bit_q - 1'b1;
    end
    if (cmd_i.next_d) begin
      // (d+1)^2 = d^2 + 2d + 1
      sq_q <= sq_q + {d_q, 1'b1};
      d_q  <= d_q + 1'b1;
    end
    if (cmd_i.publish) begin
      is_prime_q    <= cmd_i.prime;
      prime_count_q <= count_inc;
      run_end_q     <= last_q;
    end
  end

endmodule

>>> hw/rtl/prime_count_trial_division_unit.sv
// Trial-division prime counter: top level joining controller and datapath.
// Usage:
//   item_i carries one signed value and a last mark per item; result_o returns one
//   item per input with the prime flag, the running prime count of the run
//   (saturating) and an echo of last. Both channels move an item when valid and
//   ready are high at a rising clock edge.
// Flow: one item at a time. A value of 1 or less goes from accept through the
//   check straight to the result. Otherwise each tested divisor d takes a compare,
//   a bit-serial remainder over every dividend bit and an evaluate, divisors
//   running from 2 while d*d <= value; a prime n tests every d up to sqrt(n).
//   The single shared remainder unit sets the pace.
// Throughput: the next item is accepted as soon as the previous result sits in
//   the output register; it need not have been taken yet.
// Reset (rst_ni low, asynchronous): the run count clears, no result is valid and
//   the block waits for an item.
// Stall: a result held by a low result_o.ready stays put; a finished verdict waits
//   in the controller until the output register frees, holding item_i.ready low.
`timescale 1ns / 1ps

module prime_count_trial_division_unit #(
  parameter int unsigned VALUE_BITS = pcd_pkg::VALUE_BITS,
  parameter int unsigned COUNT_BITS = pcd_pkg::COUNT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcd_item_if.sink    item_i,
  pcd_result_if.source result_o
);
  import pcd_pkg::*;

  pcd_cmd_t    cmd;
  pcd_status_t sts;

  pcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcd_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (item_i.value),
    .last_i        (item_i.last),
    .is_prime_o    (result_o.is_prime),
    .prime_count_o (result_o.prime_count),
    .run_end_o     (result_o.run_end)
  );

endmodule

>>> hw/rtl/pcd_checker.sv
// Port-level checker for the prime counter, bound to the top level.
`timescale 1ns / 1ps

module pcd_checker #(
  parameter int unsigned COUNT_BITS = pcd_pkg::COUNT_BITS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  is_prime_i,
  input logic [COUNT_BITS-1:0] prime_count_i,
  input logic                  run_end_i
);

  logic                  seen_q;
  logic                  prev_end_q;
  logic [COUNT_BITS-1:0] prev_count_q;

  // Track the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      prev_end_q   <= 1'b1;
      prev_count_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      seen_q       <= 1'b1;
      prev_end_q   <= run_end_i;
      prev_count_q <= prime_count_i;
    end
  end

  // A stalled result holds valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A result never appears in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result rose while the block was idle");

  // A prime result always shows a nonzero count
  a_prime_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_prime_i |-> prime_count_i != '0)
    else $error("prime result with zero count");

  // A non-prime leaves the count as it was, or zero at the start of a run
  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_prime_i && seen_q |->
      prime_count_i == (prev_end_q ? '0 : prev_count_q))
    else $error("count changed on a non-prime");

  // A prime inside a run bumps the count by one until saturation
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_prime_i && seen_q && !prev_end_q && (prev_count_q != '1) |->
      prime_count_i == prev_count_q + 1'b1)
    else $error("count did not advance on a prime");

endmodule

bind prime_count_trial_division_unit pcd_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_pcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .is_prime_i    (result_o.is_prime),
  .prime_count_i (result_o.prime_count),
  .run_end_i     (result_o.run_end)
);
